[hw/rtl/positional_list_engine_defines.svh]
// Assertion macros used by the port-level checker of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list engine check failed");

// Next-cycle implication, disabled while reset is high.
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list engine check failed");

`endif

[hw/rtl/ple_pkg.sv]
// Shared types and constants of the positional list engine.
`default_nettype none

package ple_pkg;

  // Default list capacity.
  localparam int CAPACITY_DEFAULT = 64;

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RDWAIT,
    S_SHIFT,
    S_PUT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/positional_list_engine.sv]
// Top level of the positional list engine: sequencer, list memory and result register.
//
// Keeps an ordered list of signed 32-bit entries in a simple dual-port memory.
// A request word enters on the s_ channel (kind in s_tuser, position and value
// in s_tdata) and is taken when s_tvalid and s_tready are both high. Exactly one
// result word leaves on the m_ channel (status in m_tuser, read value and count
// in m_tdata). The block takes one request at a time: s_tready is high only
// while the sequencer is idle, and drops for the whole request.
// A failed request goes from evaluation straight to the done state; a set writes
// its entry and goes there too; a get reads through a read wait; an insert shifts the
// later entries up and then writes the new entry; a remove reads the entry and then
// shifts the later entries down. At most CAPACITY - 1 entries are moved. The next
// request can be taken in the cycle after a result is loaded. The shift loop moves
// one entry per cycle through the memory's single read port and single write port.
// The result register frees the input side: a new request is taken while the
// previous result still waits. If the receiver stalls, the next result holds
// in the sequencer until the result register is free.
// Reset empties the list and drops m_tvalid; the memory is not cleared, as no
// entry at or beyond the count is ever read.
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // position [6:0], value [38:7], zero pad [39]
  input  wire logic [7:0]  s_tuser,   // kind [1:0], zero pad [7:2]
  // Result channel.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // read_value [31:0], count [38:32], zero pad [39]
  output logic [7:0]       m_tuser    // status [1:0], zero pad [7:2]
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  ple_pkg::state_t state, state_next;

  // Request registers.
  logic [ple_pkg::KIND_W-1:0]  kind_r;
  logic [ple_pkg::POS_W-1:0]   pos_r;
  logic [ple_pkg::VALUE_W-1:0] val_r;

  // List and sequencer registers.
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 cnt_new;
  logic [ple_pkg::STATUS_W-1:0]  status_r;
  logic [ple_pkg::VALUE_W-1:0]   rd_val;
  logic [AW-1:0]                 idx_r;
  logic [AW-1:0]                 src;
  logic [AW-1:0]                 dst;
  logic [CW-1:0]                 remaining;
  logic                          pend;

  // Memory port signals.
  logic [ple_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [ple_pkg::VALUE_W-1:0] mem_rdata;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [ple_pkg::VALUE_W-1:0] mem_wdata;

  // Position checks, done in a width that holds both position and count.
  logic [CMPW-1:0]              pos_x;
  logic [CMPW-1:0]              cnt_x;
  logic [CMPW-1:0]              idx_x;
  logic [CMPW-1:0]              cnt_new_x;
  logic                         is_ins;
  logic                         bad_pos;
  logic                         is_full;
  logic                         req_ok;
  logic [ple_pkg::STATUS_W-1:0] eval_status;
  logic                         out_free;
  logic                         accept;

  assign pos_x     = CMPW'(pos_r);
  assign cnt_x     = CMPW'(cnt);
  assign idx_x     = pos_x - CMPW'(1);
  assign cnt_new_x = CMPW'(cnt_new);
  assign is_ins    = (kind_r == ple_pkg::KIND_INSERT);
  assign bad_pos   = (pos_r == '0) ||
                     (is_ins ? (pos_x > cnt_x + CMPW'(1)) : (pos_x > cnt_x));
  assign is_full   = is_ins && (cnt_x >= CMPW'(CAPACITY));
  assign req_ok    = !bad_pos && !is_full;
  assign eval_status = bad_pos ? ple_pkg::ST_BAD_POS :
                       is_full ? ple_pkg::ST_FULL    : ple_pkg::ST_OK;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ple_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ple_pkg::S_IDLE: begin
        if (accept) state_next = ple_pkg::S_EVAL;
      end
      ple_pkg::S_EVAL: begin
        if (!req_ok) begin
          state_next = ple_pkg::S_DONE;
        end else begin
          unique case (kind_r)
            ple_pkg::KIND_GET,
            ple_pkg::KIND_REMOVE: state_next = ple_pkg::S_RDWAIT;
            ple_pkg::KIND_SET:    state_next = ple_pkg::S_DONE;
            ple_pkg::KIND_INSERT: state_next = ple_pkg::S_SHIFT;
            default:              state_next = ple_pkg::S_DONE;
          endcase
        end
      end
      ple_pkg::S_RDWAIT: begin
        state_next = (kind_r == ple_pkg::KIND_REMOVE) ? ple_pkg::S_SHIFT : ple_pkg::S_DONE;
      end
      ple_pkg::S_SHIFT: begin
        if (remaining == '0 && !pend) begin
          state_next = is_ins ? ple_pkg::S_PUT : ple_pkg::S_DONE;
        end
      end
      ple_pkg::S_PUT: begin
        state_next = ple_pkg::S_DONE;
      end
      ple_pkg::S_DONE: begin
        if (out_free) state_next = ple_pkg::S_IDLE;
      end
      default: state_next = ple_pkg::S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = src;
    mem_we    = 1'b0;
    mem_waddr = dst;
    mem_wdata = mem_rdata;
    unique case (state)
      ple_pkg::S_EVAL: begin
        mem_raddr = idx_x[AW-1:0];
        mem_waddr = idx_x[AW-1:0];
        mem_wdata = val_r;
        mem_re    = req_ok && (kind_r == ple_pkg::KIND_GET || kind_r == ple_pkg::KIND_REMOVE);
        mem_we    = req_ok && (kind_r == ple_pkg::KIND_SET);
      end
      ple_pkg::S_SHIFT: begin
        mem_re = (remaining != '0);
        mem_we = pend;
      end
      ple_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = val_r;
      end
      default: begin
        mem_re = 1'b0;
        mem_we = 1'b0;
      end
    endcase
  end

  // List memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ple_pkg::S_IDLE;
      cnt      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ple_pkg::S_EVAL) begin
        pend <= 1'b0;
      end else if (state == ple_pkg::S_SHIFT) begin
        pend <= (remaining != '0);
      end
      if (state == ple_pkg::S_DONE && out_free) begin
        cnt      <= cnt_new;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request capture, shift pointers and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= s_tuser[ple_pkg::KIND_W-1:0];
      pos_r  <= s_tdata[ple_pkg::POS_W-1:0];
      val_r  <= s_tdata[ple_pkg::POS_W +: ple_pkg::VALUE_W];
    end
    unique case (state)
      ple_pkg::S_EVAL: begin
        status_r <= eval_status;
        rd_val   <= '0;
        idx_r    <= idx_x[AW-1:0];
        if (req_ok && is_ins) begin
          cnt_new   <= cnt + CW'(1);
          remaining <= CW'(cnt_x - idx_x);
          src       <= AW'(cnt_x - CMPW'(1));
        end else if (req_ok && kind_r == ple_pkg::KIND_REMOVE) begin
          cnt_new   <= cnt - CW'(1);
          remaining <= CW'(cnt_x - idx_x - CMPW'(1));
          src       <= AW'(idx_x + CMPW'(1));
        end else begin
          cnt_new   <= cnt;
          remaining <= '0;
        end
      end
      ple_pkg::S_RDWAIT: begin
        rd_val <= mem_rdata;
      end
      ple_pkg::S_SHIFT: begin
        // Insert walks down and moves each entry up; remove walks up and moves down.
        if (remaining != '0) begin
          remaining <= remaining - CW'(1);
          src       <= is_ins ? src - AW'(1) : src + AW'(1);
          dst       <= is_ins ? src + AW'(1) : src - AW'(1);
        end
      end
      ple_pkg::S_DONE: begin
        if (out_free) begin
          m_tuser <= {6'd0, status_r};
          m_tdata <= {1'b0, cnt_new_x[ple_pkg::COUNT_W-1:0], rd_val};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/ple_checker.sv]
// Port-level checker for the positional list engine, bound to the top level.
`default_nettype none

`include "positional_list_engine_defines.svh"

module ple_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [39:0] s_tdata,
  input wire logic [7:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [7:0]  m_tuser
);

  logic in_word;
  logic bad_status;

  assign in_word    = s_tvalid && s_tready && (s_tdata[39] == 1'b0 || s_tuser[7] == 1'b0 ||
                      1'b1);
  assign bad_status = (m_tuser[1:0] != ple_pkg::ST_OK);

  // One request at a time: the input closes right after a word is taken.
  `PLE_ASSERT_NEXT(a_busy_after_accept, in_word, !s_tready)

  // A failed request never returns data.
  `PLE_ASSERT_NOW(a_fail_zero_value, m_tvalid && bad_status, m_tdata[31:0] == 32'd0)

  // Only the three defined status codes appear.
  `PLE_ASSERT_NOW(a_status_code, m_tvalid, m_tuser[1:0] != 2'd3)

  // A stalled result word holds.
  `PLE_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[sim/ple_list_checker.sv]
`timescale 1ns / 1ps
// Watches both streams of the positional list engine, models the list and compares results.
module ple_list_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // position [6:0], value [38:7], zero pad [39]
  input  logic [7:0]  s_tuser,   // kind [1:0], zero pad [7:2]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // read_value [31:0], count [38:32], zero pad [39]
  input  logic [7:0]  m_tuser,   // status [1:0], zero pad [7:2]
  output int          fail_count,
  output int          pending,
  output int          list_len
);

  typedef struct packed {
    logic [ple_pkg::STATUS_W-1:0] status;
    logic [ple_pkg::VALUE_W-1:0]  read_value;
    logic [ple_pkg::COUNT_W-1:0]  count;
  } list_result_t;

  // Model of the list contents; only entries below held are meaningful.
  logic [ple_pkg::VALUE_W-1:0] list_entries [CAPACITY];
  int held;
  int mismatches;
  list_result_t awaited_results [$];

  // Applies one request word to the modeled list and returns its result.
  function automatic list_result_t apply_list_op(
      input logic [ple_pkg::KIND_W-1:0] kind,
      input logic [ple_pkg::POS_W-1:0] position,
      input logic [ple_pkg::VALUE_W-1:0] value);
    list_result_t res;
    int p;
    int idx;
    p = position;
    res.status = ple_pkg::ST_OK;
    res.read_value = '0;
    if (kind == ple_pkg::KIND_INSERT) begin
      if (p < 1 || p > held + 1) begin
        res.status = ple_pkg::ST_BAD_POS;
      end else if (held >= CAPACITY) begin
        res.status = ple_pkg::ST_FULL;
      end else begin
        // Open a hole at the position by moving later entries up.
        for (idx = held; idx > p - 1; idx--) begin
          list_entries[idx] = list_entries[idx-1];
        end
        list_entries[p-1] = value;
        held++;
      end
    end else if (p < 1 || p > held) begin
      res.status = ple_pkg::ST_BAD_POS;
    end else if (kind == ple_pkg::KIND_GET) begin
      res.read_value = list_entries[p-1];
    end else if (kind == ple_pkg::KIND_SET) begin
      list_entries[p-1] = value;
    end else begin
      // Remove returns the entry and closes the gap behind it.
      res.read_value = list_entries[p-1];
      for (idx = p - 1; idx + 1 < held; idx++) begin
        list_entries[idx] = list_entries[idx+1];
      end
      held--;
    end
    res.count = ple_pkg::COUNT_W'(held);
    return res;
  endfunction

  // Counts a failure and prints the first few of them.
  task automatic report_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Result words are matched before the request word of the same edge is modeled,
  // since a result can never belong to a request taken at that very edge.
  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (rst) begin
      held = 0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tuser[1:0];
        got.read_value = m_tdata[31:0];
        got.count = m_tdata[38:32];
        if (awaited_results.size() == 0) begin
          report_failure($sformatf("unexpected result word: status %0d value %h count %0d",
                                   got.status, got.read_value, got.count));
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            report_failure($sformatf(
                "result differs: expected status %0d value %h count %0d, got %0d %h %0d",
                want.status, want.read_value, want.count,
                got.status, got.read_value, got.count));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(apply_list_op(s_tuser[1:0], s_tdata[6:0], s_tdata[38:7]));
      end
    end
    list_len <= held;
    pending <= awaited_results.size();
    fail_count <= mismatches;
  end

endmodule

[sim/positional_list_engine_tb.sv]
`timescale 1ns / 1ps
// Testbench top of the positional list engine: clock, reset, request stimulus and verdict.
module positional_list_engine_tb;

  localparam int CAPACITY = ple_pkg::CAPACITY_DEFAULT;
  localparam int PHASE_ITEMS = 250;
  localparam int DRAIN_CYCLES = CAPACITY + 16;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} drift_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [7:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [7:0]  m_tuser;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int fail_count;
  int pending;
  int list_len;

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  positional_list_engine #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ple_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .list_len   (list_len)
  );

  // The result side stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Presents one request word after a random gap and holds it until taken.
  task automatic send_request(input logic [ple_pkg::KIND_W-1:0] kind,
                              input logic [ple_pkg::POS_W-1:0] position,
                              input logic [ple_pkg::VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, value, position};
    s_tuser <= {6'b0, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops sending and waits until every outstanding result word has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly random values, with the signed extremes, all-ones and zero mixed in.
  function automatic logic [ple_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // One random request: the kind mix follows the drift, positions are mostly in range.
  task automatic send_random(input drift_t mode);
    int roll;
    int n;
    int last;
    logic [ple_pkg::KIND_W-1:0] kind;
    logic [ple_pkg::POS_W-1:0] position;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        kind = roll < 70 ? ple_pkg::KIND_INSERT : roll < 80 ? ple_pkg::KIND_GET :
               roll < 90 ? ple_pkg::KIND_SET : ple_pkg::KIND_REMOVE;
      end
      MODE_SHRINK: begin
        kind = roll < 60 ? ple_pkg::KIND_REMOVE : roll < 75 ? ple_pkg::KIND_INSERT :
               roll < 90 ? ple_pkg::KIND_GET : ple_pkg::KIND_SET;
      end
      default: kind = ple_pkg::KIND_W'($urandom_range(0, 3));
    endcase
    n = list_len;
    last = (kind == ple_pkg::KIND_INSERT) ? n + 1 : n;
    roll = $urandom_range(0, 99);
    if (roll < 85 && last >= 1) begin
      if (roll < 8) begin
        position = ple_pkg::POS_W'(1);
      end else if (roll < 16) begin
        position = ple_pkg::POS_W'(last);
      end else begin
        position = ple_pkg::POS_W'($urandom_range(1, last));
      end
    end else begin
      // Noise: position zero, just past the end, or anything at all.
      case ($urandom_range(0, 3))
        0: position = '0;
        1: position = ple_pkg::POS_W'(last + 1);
        2: position = ple_pkg::POS_W'(n + 2);
        default: position = ple_pkg::POS_W'($urandom_range(0, 127));
      endcase
    end
    send_request(kind, position, pick_value());
  endtask

  // A run of random requests whose drift changes every few dozen words.
  task automatic run_random(input int items);
    drift_t mode;
    int left;
    left = 0;
    mode = MODE_MIXED;
    for (int i = 0; i < items; i++) begin
      if (left == 0) begin
        mode = drift_t'($urandom_range(0, 2));
        left = $urandom_range(20, 80);
      end
      left--;
      send_random(mode);
    end
  endtask

  // Main sequence: reset, directed cases, then three paced random phases.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 28;
    rx_idle_pct <= 86;
    @(posedge clk);

    // Empty list: every access is a bad position, as is insert past count+1.
    send_request(ple_pkg::KIND_GET, 7'd1, 32'h0000_0001);
    send_request(ple_pkg::KIND_SET, 7'd1, 32'hFFFF_FFFF);
    send_request(ple_pkg::KIND_REMOVE, 7'd1, 32'h0);
    send_request(ple_pkg::KIND_INSERT, 7'd0, 32'h1234_5678);
    send_request(ple_pkg::KIND_INSERT, 7'd2, 32'h1234_5678);
    send_request(ple_pkg::KIND_GET, 7'd0, 32'h0);
    // Build a short list at the front, the end and the middle.
    send_request(ple_pkg::KIND_INSERT, 7'd1, 32'h8000_0000);
    send_request(ple_pkg::KIND_INSERT, 7'd2, 32'h7FFF_FFFF);
    send_request(ple_pkg::KIND_INSERT, 7'd1, 32'hFFFF_FFFF);
    send_request(ple_pkg::KIND_INSERT, 7'd4, 32'h0000_0000);
    send_request(ple_pkg::KIND_INSERT, 7'd2, 32'h1234_5678);
    // Reads at and past the end, writes with alternating bit patterns.
    send_request(ple_pkg::KIND_GET, 7'd5, 32'h0);
    send_request(ple_pkg::KIND_GET, 7'd6, 32'h0);
    send_request(ple_pkg::KIND_GET, 7'd127, 32'h0);
    send_request(ple_pkg::KIND_SET, 7'd0, 32'hAAAA_AAAA);
    send_request(ple_pkg::KIND_SET, 7'd5, 32'hAAAA_AAAA);
    send_request(ple_pkg::KIND_SET, 7'd3, 32'h5555_5555);
    send_request(ple_pkg::KIND_GET, 7'd3, 32'h0);
    // Removal from the middle, the end and the front, plus bad positions.
    send_request(ple_pkg::KIND_REMOVE, 7'd0, 32'h0);
    send_request(ple_pkg::KIND_REMOVE, 7'd6, 32'h0);
    send_request(ple_pkg::KIND_REMOVE, 7'd3, 32'h0);
    send_request(ple_pkg::KIND_REMOVE, 7'd4, 32'h0);
    send_request(ple_pkg::KIND_REMOVE, 7'd1, 32'h0);
    send_request(ple_pkg::KIND_INSERT, 7'd127, 32'h0);
    send_request(ple_pkg::KIND_GET, 7'd1, 32'h0);
    wait_drained();

    // Sender rarely idle, receiver mostly stalled.
    run_random(PHASE_ITEMS);
    wait_drained();

    // Sender mostly idle, receiver rarely stalled.
    tx_idle_pct = 86;
    rx_idle_pct <= 28;
    run_random(PHASE_ITEMS);
    wait_drained();

    // No idling: fill the list to capacity, probe the full cases, then keep going.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    while (list_len < CAPACITY) begin
      send_request(ple_pkg::KIND_INSERT, ple_pkg::POS_W'($urandom_range(1, list_len + 1)),
                   pick_value());
    end
    wait_drained();
    send_request(ple_pkg::KIND_INSERT, ple_pkg::POS_W'($urandom_range(1, CAPACITY + 1)),
                 pick_value());
    send_request(ple_pkg::KIND_INSERT, ple_pkg::POS_W'(CAPACITY + 2), pick_value());
    send_request(ple_pkg::KIND_GET, ple_pkg::POS_W'(CAPACITY), 32'h0);
    send_request(ple_pkg::KIND_REMOVE, ple_pkg::POS_W'(CAPACITY), 32'h0);
    run_random(PHASE_ITEMS - CAPACITY);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("positional_list_engine: match");
    end else begin
      $display("positional_list_engine: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("positional_list_engine: mismatch");
    $finish;
  end

endmodule
